FILE: sv/tnb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnb_pkg
// Shared types and constants for the text number token to byte converter.
// ----------------------------------------------------------------------------
package tnb_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } byte_item_t;

  // One converted number waiting to be split into bytes
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  word_bytes;
    logic        little_order;
  } word_req_t;

  localparam logic [47:0] KW_UINT32 = "uint32";
  localparam logic [47:0] KW_UINT24 = "uint24";
  localparam logic [47:0] KW_UINT16 = "uint16";
  localparam logic [39:0] KW_UINT8  = "uint8";
  localparam logic [15:0] KW_LE     = "le";
  localparam logic [15:0] KW_BE     = "be";

  localparam int unsigned KEY_SLOTS = 6;
  localparam logic [3:0]  LEN_MAX   = 4'd15;

  localparam logic [31:0] DEC_LIMIT = 32'd429496729;
  localparam logic [31:0] HEX_LIMIT = 32'h0FFF_FFFF;

  localparam logic [2:0] WB_1 = 3'd1;
  localparam logic [2:0] WB_2 = 3'd2;
  localparam logic [2:0] WB_3 = 3'd3;
  localparam logic [2:0] WB_4 = 3'd4;

endpackage

FILE: sv/tnb_token.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnb_token
// Token tracker: accumulates decimal and hex values, matches keywords and
// issues a word request when a numeric token closes.
// ----------------------------------------------------------------------------
module tnb_token
  import tnb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  char_item_t item,
  output logic       emit,
  output word_req_t  word
);

  logic [2:0]  word_bytes;
  logic        little_order;
  logic        in_token;
  logic [3:0]  token_length;
  logic [7:0]  keyword_chars [KEY_SLOTS];
  logic [31:0] decimal_accum;
  logic        decimal_valid;
  logic [31:0] hex_accum;
  logic        hex_valid;
  logic        hex_prefix_seen;

  logic [2:0]  word_bytes_next;
  logic        little_order_next;
  logic        in_token_next;
  logic [3:0]  token_length_next;
  logic [31:0] decimal_accum_next;
  logic        decimal_valid_next;
  logic [31:0] hex_accum_next;
  logic        hex_valid_next;
  logic        hex_prefix_seen_next;

  logic [7:0]  c;
  logic        blank;
  logic        close;
  logic        is_dec;
  logic [3:0]  dec_digit;
  logic [4:0]  hex_digit;
  logic        prefix_char;
  logic [47:0] key6;
  logic [39:0] key5;
  logic [15:0] key2;
  logic        kw_u32, kw_u24, kw_u16, kw_u8, kw_le, kw_be, kw_any;
  logic        num_dec, num_hex;

  assign c     = item.char_code;
  assign blank = c inside {8'h20, [8'h09:8'h0D]};
  assign close = item.end_of_text || (blank && in_token);

  assign key6 = {keyword_chars[0], keyword_chars[1], keyword_chars[2],
                 keyword_chars[3], keyword_chars[4], keyword_chars[5]};
  assign key5 = key6[47:8];
  assign key2 = key6[47:32];

  assign kw_u32 = (token_length == 4'd6) && (key6 == KW_UINT32);
  assign kw_u24 = (token_length == 4'd6) && (key6 == KW_UINT24);
  assign kw_u16 = (token_length == 4'd6) && (key6 == KW_UINT16);
  assign kw_u8  = (token_length == 4'd5) && (key5 == KW_UINT8);
  assign kw_le  = (token_length == 4'd2) && (key2 == KW_LE);
  assign kw_be  = (token_length == 4'd2) && (key2 == KW_BE);
  assign kw_any = kw_u32 | kw_u24 | kw_u16 | kw_u8 | kw_le | kw_be;

  assign num_dec = decimal_valid;
  assign num_hex = hex_valid && !(hex_prefix_seen && token_length == 4'd2);

  assign emit = take && close && in_token && !kw_any && (num_dec || num_hex);
  assign word.value        = num_dec ? decimal_accum : hex_accum;
  assign word.word_bytes   = word_bytes;
  assign word.little_order = little_order;

  assign is_dec    = c inside {[8'h30:8'h39]};
  assign dec_digit = 4'(c - 8'h30);
  assign prefix_char = (token_length == 4'd1) && !hex_prefix_seen &&
                       (keyword_chars[0] == 8'h30) && (c == 8'h78 || c == 8'h58);

  always_comb begin
    if (is_dec) begin
      hex_digit = 5'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      hex_digit = 5'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      hex_digit = 5'(c - 8'h37);
    end else begin
      hex_digit = 5'd16;
    end
  end

  always_comb begin
    word_bytes_next      = word_bytes;
    little_order_next    = little_order;
    in_token_next        = in_token;
    token_length_next    = token_length;
    decimal_accum_next   = decimal_accum;
    decimal_valid_next   = decimal_valid;
    hex_accum_next       = hex_accum;
    hex_valid_next       = hex_valid;
    hex_prefix_seen_next = hex_prefix_seen;
    if (take) begin
      if (close) begin
        if (in_token) begin
          if (kw_u32) begin
            word_bytes_next = WB_4;
          end else if (kw_u24) begin
            word_bytes_next = WB_3;
          end else if (kw_u16) begin
            word_bytes_next = WB_2;
          end else if (kw_u8) begin
            word_bytes_next = WB_1;
          end else if (kw_le) begin
            little_order_next = 1'b1;
          end else if (kw_be) begin
            little_order_next = 1'b0;
          end
        end
        if (item.end_of_text) begin
          word_bytes_next   = WB_1;
          little_order_next = 1'b1;
        end
        in_token_next        = 1'b0;
        token_length_next    = '0;
        decimal_accum_next   = '0;
        decimal_valid_next   = 1'b1;
        hex_accum_next       = '0;
        hex_valid_next       = 1'b1;
        hex_prefix_seen_next = 1'b0;
      end else if (!blank) begin
        if (is_dec) begin
          if (decimal_accum > DEC_LIMIT ||
              (decimal_accum == DEC_LIMIT && dec_digit > 4'd5)) begin
            decimal_valid_next = 1'b0;
          end else begin
            decimal_accum_next = (decimal_accum << 3) + (decimal_accum << 1) +
                                 {28'd0, dec_digit};
          end
        end else begin
          decimal_valid_next = 1'b0;
        end
        if (prefix_char) begin
          hex_prefix_seen_next = 1'b1;
        end else if (hex_digit[4] || hex_accum > HEX_LIMIT) begin
          hex_valid_next = 1'b0;
        end else begin
          hex_accum_next = {hex_accum[27:0], hex_digit[3:0]};
        end
        in_token_next = 1'b1;
        if (token_length != LEN_MAX) begin
          token_length_next = token_length + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_bytes      <= WB_1;
      little_order    <= 1'b1;
      in_token        <= 1'b0;
      token_length    <= '0;
      decimal_accum   <= '0;
      decimal_valid   <= 1'b1;
      hex_accum       <= '0;
      hex_valid       <= 1'b1;
      hex_prefix_seen <= 1'b0;
    end else begin
      word_bytes      <= word_bytes_next;
      little_order    <= little_order_next;
      in_token        <= in_token_next;
      token_length    <= token_length_next;
      decimal_accum   <= decimal_accum_next;
      decimal_valid   <= decimal_valid_next;
      hex_accum       <= hex_accum_next;
      hex_valid       <= hex_valid_next;
      hex_prefix_seen <= hex_prefix_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !close && !blank && token_length < 4'(KEY_SLOTS)) begin
      keyword_chars[token_length[2:0]] <= c;
    end
  end

endmodule

FILE: sv/tnb_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnb_emit
// Byte emitter: one pending word slot and one active word that is sent a
// byte per request in the selected order.
// ----------------------------------------------------------------------------
module tnb_emit
  import tnb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  word_req_t  word,
  output logic       space,
  output logic       byte_valid,
  input  logic       byte_ready,
  output byte_item_t byte_item
);

  logic       pend_valid;
  word_req_t  pend;
  logic       act_valid;
  word_req_t  act;
  logic [1:0] k;

  logic       last;
  logic       act_done;
  logic       act_free;
  logic       move;
  logic [1:0] idx;

  assign last     = ({1'b0, k} + 3'd1) == act.word_bytes;
  assign act_done = act_valid && byte_ready && last;
  assign act_free = !act_valid || act_done;
  assign move     = pend_valid && act_free;
  assign space    = !pend_valid || act_free;

  assign idx = act.little_order ? k : 2'(act.word_bytes - 3'd1) - k;

  assign byte_valid          = act_valid;
  assign byte_item.out_byte  = act.value[{idx, 3'b000} +: 8];
  assign byte_item.last_byte = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      act_valid  <= 1'b0;
      k          <= '0;
    end else begin
      if (load) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        act_valid <= 1'b1;
        k         <= '0;
      end else if (act_done) begin
        act_valid <= 1'b0;
      end else if (act_valid && byte_ready) begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend <= word;
    end
    if (move) begin
      act <= pend;
    end
  end

endmodule

FILE: sv/text_number_tokens_to_bytes_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_number_tokens_to_bytes_top
// Converts a character stream of keywords and numbers into binary bytes.
// ----------------------------------------------------------------------------
// Input channel char_*: one character (or an end-of-text mark) per request.
// Output channel byte_*: one byte per request, last_byte set on the final
// byte of each number. Keywords uint8/16/24/32 and le/be set word size and
// byte order; other tokens are read as decimal, then hex, else dropped.
// Throughput: one character per cycle. A number of N bytes holds the
// output until its N bytes are taken; the byte emitter has one pending
// word slot behind the active word, and char_ready drops while that slot
// holds a word and an active word is not handing over its last byte in
// the same cycle. A closing whitespace or end-of-text request loads the
// number into the pending slot, from which it moves to the active word on
// byte_* when that is free. Reset (rst, synchronous): word size 1, little
// endian, no token, no bytes. A stalled receiver holds the current byte;
// characters keep flowing until the pending slot is full.
// ----------------------------------------------------------------------------
module text_number_tokens_to_bytes_top
  import tnb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  char_item_t char_item,
  output logic       byte_valid,
  input  logic       byte_ready,
  output byte_item_t byte_item
);

  logic      take;
  logic      emit;
  word_req_t word;

  assign take = char_valid && char_ready;

  tnb_token u_token (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (char_item),
    .emit (emit),
    .word (word)
  );

  tnb_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (emit),
    .word       (word),
    .space      (char_ready),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item)
  );

endmodule

FILE: sv/tnb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnb_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module tnb_checker
  import tnb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_ready,
  input char_item_t char_item,
  input logic       byte_valid,
  input logic       byte_ready,
  input byte_item_t byte_item
);

  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_ready |=> byte_valid && $stable(byte_item))
    else $error("stalled byte changed or dropped");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !byte_valid)
    else $error("byte shown after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !char_ready |-> byte_valid)
    else $error("input stalled with no byte pending");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready && !byte_item.last_byte |=> byte_valid)
    else $error("number run broken before last byte");

endmodule

bind text_number_tokens_to_bytes_top tnb_checker u_tnb_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .char_item  (char_item),
  .byte_valid (byte_valid),
  .byte_ready (byte_ready),
  .byte_item  (byte_item)
);
